FILE: rtl/pss_pkg.sv
// ============================================================================
// pss_pkg: shared types and constants of the pattern step sequencer
// Command and result beat layouts, the step word, configuration fields and
// the fixed timing constants of the transport and gate logic.
// ============================================================================
package pss_pkg;

    // Default geometry of the step store.
    localparam int PATTERNS_DEF = 4;
    localparam int STEPS_DEF    = 32;

    // Step period clamp and gate arithmetic.
    localparam int PERIOD_MIN   = 20;
    localparam int PERIOD_MAX   = 2000;
    localparam int GATE_DIV     = 100;
    localparam int GATE_MIN     = 10;
    localparam int GATE_PCT_MAX = 95;
    localparam int GATE_PCT_DEF = 75;
    localparam int GATE_PROD_W  = 18;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_GWAVE_EN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GWAVE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMP_EN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 3'd4;

    localparam logic [9:0]  GAMP_RESET   = 10'd512;
    localparam logic [10:0] PERIOD_RESET = 11'd250;

    // Transport codes as reported in the result beat.
    localparam logic [1:0] TR_STOPPED = 2'd0;
    localparam logic [1:0] TR_PLAYING = 2'd1;
    localparam logic [1:0] TR_PAUSED  = 2'd2;

    // Command kinds.
    typedef enum logic [2:0] {
        K_TICK     = 3'd0,
        K_PLAY     = 3'd1,
        K_PAUSE    = 3'd2,
        K_STOP     = 3'd3,
        K_SELECT   = 3'd4,
        K_SET_NOTE = 3'd5,
        K_SET_REST = 3'd6,
        K_TOGGLE   = 3'd7
    } kind_t;

    // One stored step, 28 bits.
    typedef struct packed {
        logic [1:0] wave;
        logic [6:0] gate;
        logic [9:0] amp;
        logic [6:0] note;
        logic       rest;
        logic       active;
    } step_t;

    // Contents of a step after reset: inactive rest, all other fields zero.
    localparam step_t STEP_RESET = '{wave: 2'd0, gate: 7'd0, amp: 10'd0,
                                     note: 7'd0, rest: 1'b1, active: 1'b0};

    // Command beat.
    typedef struct packed {
        kind_t      kind;
        logic [1:0] pattern_index;
        logic [4:0] step_index;
        logic [6:0] midi_note;
        logic [9:0] amplitude;
        logic [7:0] gate_percent;
        logic [1:0] wave;
    } req_t;

    // Result beat.
    typedef struct packed {
        logic       note_off;
        logic       note_on;
        logic [6:0] note_midi;
        logic [9:0] note_amp;
        logic [1:0] note_wave;
        logic [4:0] current_step;
        logic [1:0] transport;
        logic       queried_active;
        logic       queried_has_note;
    } rsp_t;

    // Configuration as seen by the sequencer core; period is already clamped.
    typedef struct packed {
        logic        gwave_en;
        logic [1:0]  gwave;
        logic        gamp_en;
        logic [9:0]  gamp;
        logic [10:0] period;
    } cfg_t;

endpackage

FILE: rtl/pss_step_mem.sv
// ============================================================================
// pss_step_mem: step store
// One write port and two registered read ports. Per-entry valid bits make
// entries that were never written read as the reset step.
// ============================================================================
module pss_step_mem #(
    parameter int  DEPTH  = pss_pkg::PATTERNS_DEF * pss_pkg::STEPS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr_a,
    input  logic [ADDR_W-1:0]  rd_addr_b,
    output pss_pkg::step_t     rd_data_a,
    output pss_pkg::step_t     rd_data_b,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  pss_pkg::step_t     wr_data
);
    import pss_pkg::*;

    step_t            mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    step_t            rd_a_reg;
    step_t            rd_b_reg;
    logic             rd_a_valid_reg;
    logic             rd_b_valid_reg;

    // Storage array: write and both reads are synchronous.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    // Valid bits, cleared at reset, sampled along with the read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            rd_a_valid_reg <= 1'b0;
            rd_b_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_a_valid_reg <= valid_reg[rd_addr_a];
                rd_b_valid_reg <= valid_reg[rd_addr_b];
            end
        end
    end

    // An entry never written reads as the reset step.
    assign rd_data_a = rd_a_valid_reg ? rd_a_reg : STEP_RESET;
    assign rd_data_b = rd_b_valid_reg ? rd_b_reg : STEP_RESET;

endmodule

FILE: rtl/pss_core.sv
// ============================================================================
// pss_core: transport, gate and edit logic of the step sequencer
// Issues the store reads when a command is taken, then on commit updates the
// transport state, counters and gate, writes back edited steps and forms the
// result beat.
// ============================================================================
module pss_core #(
    parameter int  PATTERNS = pss_pkg::PATTERNS_DEF,
    parameter int  STEPS    = pss_pkg::STEPS_DEF,
    localparam int DEPTH    = PATTERNS * STEPS,
    localparam int ADDR_W   = $clog2(DEPTH),
    localparam int POS_W    = $clog2(STEPS),
    localparam int PAT_W    = (PATTERNS > 1) ? $clog2(PATTERNS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               commit,
    input  pss_pkg::req_t      req,
    input  pss_pkg::cfg_t      cfg,
    output logic [ADDR_W-1:0]  rd_addr_a,
    output logic [ADDR_W-1:0]  rd_addr_b,
    input  pss_pkg::step_t     rd_data_a,
    input  pss_pkg::step_t     rd_data_b,
    output logic               wr_en,
    output logic [ADDR_W-1:0]  wr_addr,
    output pss_pkg::step_t     wr_data,
    output pss_pkg::rsp_t      result
);
    import pss_pkg::*;

    typedef enum logic [2:0] {
        ST_STOPPED = 3'b001,
        ST_PLAYING = 3'b010,
        ST_PAUSED  = 3'b100
    } trans_state_t;

    localparam logic [ADDR_W-1:0] STEPS_A  = ADDR_W'(STEPS);
    localparam logic [POS_W-1:0]  POS_LAST = POS_W'(STEPS - 1);

    trans_state_t            trans_reg, trans_next;
    logic [PAT_W-1:0]        pat_reg, pat_next;
    logic [POS_W-1:0]        pos_reg, pos_next, pos_inc;
    logic [10:0]             period_cnt_reg, period_cnt_next;
    logic [10:0]             gate_cnt_reg, gate_cnt_next;
    logic [GATE_PROD_W-1:0]  gate_prod_reg, gate_prod_next;
    logic                    gate_on_reg, gate_on_next;
    req_t                    item_reg;
    logic [ADDR_W-1:0]       addr_b_reg;
    logic [POS_W-1:0]        req_step;
    logic [PAT_W-1:0]        rd_pat;
    logic                    sidx_ok;
    logic [11:0]             gc1;
    logic [11:0]             pc1;
    logic                    gate_expire;
    logic                    edit_en;
    step_t                   edit_word;
    step_t                   query_word;
    logic                    off, on;
    logic [6:0]              on_note;
    logic [9:0]              on_amp;
    logic [1:0]              on_wave;
    logic [1:0]              trans_code;

    // Read addresses: the step after the current position and the queried step.
    // A pattern select queries the step in the pattern that it chooses.
    assign pos_inc   = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
    assign req_step  = (32'(req.step_index) < STEPS) ? POS_W'(req.step_index) : POS_LAST;
    assign rd_pat    = (req.kind == K_SELECT && 32'(req.pattern_index) < PATTERNS)
                       ? PAT_W'(req.pattern_index) : pat_reg;
    assign rd_addr_a = ADDR_W'(pat_reg) * STEPS_A + ADDR_W'(pos_inc);
    assign rd_addr_b = ADDR_W'(rd_pat) * STEPS_A + ADDR_W'(req_step);

    // Hold the command and its edit address until commit.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            item_reg   <= req;
            addr_b_reg <= rd_addr_b;
        end
    end

    // Gate expiry: count >= max(prod / 100, 10) without a divider.
    assign sidx_ok     = 32'(item_reg.step_index) < STEPS;
    assign gc1         = {1'b0, gate_cnt_reg} + 12'd1;
    assign pc1         = {1'b0, period_cnt_reg} + 12'd1;
    assign gate_expire = (19'(gc1) * 19'(GATE_DIV) + 19'(GATE_DIV - 1)
                          >= 19'(gate_prod_reg)) && (gc1 >= 12'(GATE_MIN));

    // Command execution.
    always_comb
    begin
        logic gate_live;
        logic [7:0] gpct;
        trans_next      = trans_reg;
        pat_next        = pat_reg;
        pos_next        = pos_reg;
        period_cnt_next = period_cnt_reg;
        gate_cnt_next   = gate_cnt_reg;
        gate_prod_next  = gate_prod_reg;
        gate_on_next    = gate_on_reg;
        off             = 1'b0;
        on              = 1'b0;
        on_note         = '0;
        on_amp          = '0;
        on_wave         = '0;
        edit_en         = 1'b0;
        edit_word       = rd_data_b;
        gate_live       = gate_on_reg;
        gpct            = item_reg.gate_percent;

        unique case (item_reg.kind)
            K_TICK:
            begin
                if (trans_reg == ST_PLAYING)
                begin
                    if (gate_on_reg)
                    begin
                        gate_cnt_next = 11'(gc1);
                        if (gate_expire)
                        begin
                            off       = 1'b1;
                            gate_live = 1'b0;
                        end
                    end
                    if (pc1 >= {1'b0, cfg.period})
                    begin
                        period_cnt_next = '0;
                        pos_next        = pos_inc;
                        if (gate_live)
                        begin
                            off = 1'b1;
                        end
                        if (!rd_data_a.active || rd_data_a.rest)
                        begin
                            off       = 1'b1;
                            gate_live = 1'b0;
                        end
                        else
                        begin
                            on             = 1'b1;
                            on_note        = rd_data_a.note;
                            on_amp         = cfg.gamp_en ? cfg.gamp : rd_data_a.amp;
                            on_wave        = cfg.gwave_en ? cfg.gwave : rd_data_a.wave;
                            gate_prod_next = GATE_PROD_W'(cfg.period)
                                             * GATE_PROD_W'(rd_data_a.gate);
                            gate_cnt_next  = '0;
                            gate_live      = 1'b1;
                        end
                    end
                    else
                    begin
                        period_cnt_next = 11'(pc1);
                    end
                    gate_on_next = gate_live;
                end
            end
            K_PLAY:
            begin
                if (trans_reg != ST_PLAYING)
                begin
                    if (trans_reg == ST_STOPPED)
                    begin
                        pos_next = POS_LAST;
                    end
                    trans_next      = ST_PLAYING;
                    period_cnt_next = '0;
                end
            end
            K_PAUSE:
            begin
                if (trans_reg == ST_PLAYING)
                begin
                    trans_next   = ST_PAUSED;
                    off          = gate_on_reg;
                    gate_on_next = 1'b0;
                end
                else if (trans_reg == ST_PAUSED)
                begin
                    trans_next      = ST_PLAYING;
                    period_cnt_next = '0;
                end
            end
            K_STOP:
            begin
                off          = 1'b1;
                gate_on_next = 1'b0;
                pos_next     = '0;
                trans_next   = ST_STOPPED;
            end
            K_SELECT:
            begin
                if (32'(item_reg.pattern_index) < PATTERNS)
                begin
                    pat_next = PAT_W'(item_reg.pattern_index);
                end
            end
            K_SET_NOTE:
            begin
                edit_en          = sidx_ok;
                edit_word.active = 1'b1;
                edit_word.rest   = 1'b0;
                edit_word.note   = item_reg.midi_note;
                edit_word.amp    = item_reg.amplitude;
                edit_word.wave   = item_reg.wave;
                if (gpct > 8'd0 && gpct <= 8'(GATE_PCT_MAX))
                begin
                    edit_word.gate = 7'(gpct);
                end
                else
                begin
                    edit_word.gate = 7'(GATE_PCT_DEF);
                end
            end
            K_SET_REST:
            begin
                edit_en          = sidx_ok;
                edit_word.note   = '0;
                edit_word.active = 1'b1;
                edit_word.rest   = 1'b1;
            end
            K_TOGGLE:
            begin
                edit_en          = sidx_ok;
                edit_word.active = ~rd_data_b.active;
            end
            default:
            begin
            end
        endcase
    end

    // Write-back of edited steps.
    assign wr_en      = commit && edit_en;
    assign wr_addr    = addr_b_reg;
    assign wr_data    = edit_word;
    assign query_word = edit_en ? edit_word : rd_data_b;

    // Transport code for the result beat.
    always_comb
    begin
        unique case (trans_next)
            ST_STOPPED: trans_code = TR_STOPPED;
            ST_PLAYING: trans_code = TR_PLAYING;
            ST_PAUSED:  trans_code = TR_PAUSED;
            default:    trans_code = TR_STOPPED;
        endcase
    end

    // Result beat.
    always_comb
    begin
        result.note_off         = off;
        result.note_on          = on;
        result.note_midi        = on_note;
        result.note_amp         = on_amp;
        result.note_wave        = on_wave;
        result.current_step     = 5'(pos_next);
        result.transport        = trans_code;
        result.queried_active   = sidx_ok && query_word.active;
        result.queried_has_note = sidx_ok && query_word.active && !query_word.rest;
    end

    // Sequencer state, updated once per command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trans_reg      <= ST_STOPPED;
            pat_reg        <= '0;
            pos_reg        <= '0;
            period_cnt_reg <= '0;
            gate_cnt_reg   <= '0;
            gate_prod_reg  <= '0;
            gate_on_reg    <= 1'b0;
        end
        else if (commit)
        begin
            trans_reg      <= trans_next;
            pat_reg        <= pat_next;
            pos_reg        <= pos_next;
            period_cnt_reg <= period_cnt_next;
            gate_cnt_reg   <= gate_cnt_next;
            gate_prod_reg  <= gate_prod_next;
            gate_on_reg    <= gate_on_next;
        end
    end

endmodule

FILE: rtl/pattern_step_sequencer.sv
// ============================================================================
// pattern_step_sequencer: step sequencer with a pattern store
// Top level: configuration registers, command handshake, result register,
// the step store and the sequencer core.
// ============================================================================
// Usage
//   Command beats (ticks, transport and edit commands) arrive on req with
//   req_valid / req_stall; one result beat per command leaves on rsp with
//   rsp_valid / rsp_stall. Configuration registers are written through
//   cfg_valid / cfg_ready / cfg_index / cfg_data; the user must write them
//   only while no command is in flight, as the block does not enforce it.
//   The step store is read at the accepting edge; state update, write-back and
//   the result register load happen at commit, once the result register is free
//   or being emptied, and rsp_valid rises with that load. A new command is taken
//   only after the previous one has committed. When the receiver stalls, one
//   more command is taken and held until the result register frees; req_stall
//   stays high meanwhile. Reset stops the transport, selects pattern 0, loads
//   the register defaults and marks every stored step as cleared through
//   per-entry valid bits, so the block takes commands as soon as reset ends.
// ============================================================================
module pattern_step_sequencer #(
    parameter int PATTERNS = pss_pkg::PATTERNS_DEF,
    parameter int STEPS    = pss_pkg::STEPS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  pss_pkg::req_t                    req,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output pss_pkg::rsp_t                    rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pss_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pss_pkg::*;

    localparam int DEPTH  = PATTERNS * STEPS;
    localparam int ADDR_W = $clog2(DEPTH);

    cfg_t               cfg_reg;
    logic               busy_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;
    logic               accept;
    logic               commit;
    logic [ADDR_W-1:0]  rd_addr_a, rd_addr_b, wr_addr;
    step_t              rd_data_a, rd_data_b, wr_data;
    logic               wr_en;
    rsp_t               core_rsp;
    logic [10:0]        period_clamped;

    // Command handshake: one command in flight, committed once the result
    // register is free or being emptied.
    assign req_stall = busy_reg;
    assign accept    = req_valid && !busy_reg;
    assign commit    = busy_reg && (!rsp_valid_reg || !rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (commit)
            begin
                busy_reg <= 1'b0;
            end
            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            rsp_reg <= core_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Configuration registers; the step period is stored already clamped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (cfg_data < 11'(PERIOD_MIN))
        begin
            period_clamped = 11'(PERIOD_MIN);
        end
        else if (cfg_data > 11'(PERIOD_MAX))
        begin
            period_clamped = 11'(PERIOD_MAX);
        end
        else
        begin
            period_clamped = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gwave_en <= 1'b0;
            cfg_reg.gwave    <= '0;
            cfg_reg.gamp_en  <= 1'b0;
            cfg_reg.gamp     <= GAMP_RESET;
            cfg_reg.period   <= PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GWAVE_EN: cfg_reg.gwave_en <= cfg_data[0];
                CFG_GWAVE:    cfg_reg.gwave    <= cfg_data[1:0];
                CFG_GAMP_EN:  cfg_reg.gamp_en  <= cfg_data[0];
                CFG_GAMP:     cfg_reg.gamp     <= cfg_data[9:0];
                CFG_PERIOD:   cfg_reg.period   <= period_clamped;
                default:
                begin
                end
            endcase
        end
    end

    // Step store.
    pss_step_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // Sequencer core.
    pss_core #(
        .PATTERNS (PATTERNS),
        .STEPS    (STEPS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .commit    (commit),
        .req       (req),
        .cfg       (cfg_reg),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .result    (core_rsp)
    );

`ifndef NO_ASSERTIONS
    // A command needs its read cycle before the next one is taken.
    a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !accept)
        else $error("command taken in the cycle after another");

    // A committed command always shows up in the result register.
    a_commit_fills: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> rsp_valid)
        else $error("committed result not presented");

    // Note-ons only happen while playing.
    a_note_on_playing: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.note_on |-> rsp.transport == TR_PLAYING)
        else $error("note-on reported outside play");

    // Note fields are zero in a beat without a note-on.
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.note_on |->
            rsp.note_midi == 7'd0 && rsp.note_amp == 10'd0 && rsp.note_wave == 2'd0)
        else $error("note fields set without a note-on");
`endif

endmodule
